>>> rtl/core/credit_gate_with_onset_offset_delay_assert.svh
// assertion macros used by the checker file of the credit gate
`ifndef CREDIT_GATE_WITH_ONSET_OFFSET_DELAY_ASSERT_SVH
`define CREDIT_GATE_WITH_ONSET_OFFSET_DELAY_ASSERT_SVH

// same-cycle implication, clocked on clk_i, held off while rst_ni is low
`define CG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, held off while rst_ni is low
`define CG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cgate_pkg.sv
// types, constants and helper functions of the credit gate
`timescale 1ns / 1ps

package cgate_pkg;

  // time and credit format
  localparam int TimeBits       = 32;
  localparam int CreditFracBits = 16;
  localparam int CreditBits     = CreditFracBits + 2;
  localparam logic [CreditBits-1:0] CreditOne = CreditBits'(1) << CreditFracBits;
  localparam logic [CreditBits-1:0] CreditCap = CreditOne << 1;

  // field widths
  localparam int NowBits     = 32;
  localparam int DelayBits   = 20;
  localparam int DivBits     = DelayBits + 1;
  localparam int RefillBits  = 10;
  localparam int RngBits     = 32;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 32;

  // refill window
  localparam int WinMax   = 100000;
  localparam int WinBits  = $clog2(WinMax + 1);
  localparam int ProdBits = WinBits + RefillBits;
  localparam int SumBits  = ((ProdBits > CreditBits) ? ProdBits : CreditBits) + 1;

  // reset values of the registers
  localparam logic                   EnableRst    = 1'b0;
  localparam logic [DelayBits-1:0]   OnsetMinRst  = DelayBits'(1000);
  localparam logic [DelayBits-1:0]   OnsetMaxRst  = DelayBits'(3000);
  localparam logic [DelayBits-1:0]   OffsetMinRst = DelayBits'(2000);
  localparam logic [DelayBits-1:0]   OffsetMaxRst = DelayBits'(6000);
  localparam logic [RefillBits-1:0]  RefillRst    = RefillBits'(32);
  localparam logic [RngBits-1:0]     SeedRst      = 32'hA5C37E91;
  localparam logic [RngBits-1:0]     SeedFallback = 32'hA5C37E91;

  typedef logic [TimeBits-1:0] time_t;

  typedef enum logic {
    OP_SEND = 1'b0,
    OP_STOP = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ENABLE     = 3'd0,
    REG_ONSET_MIN  = 3'd1,
    REG_ONSET_MAX  = 3'd2,
    REG_OFFSET_MIN = 3'd3,
    REG_OFFSET_MAX = 3'd4,
    REG_REFILL     = 3'd5,
    REG_RNG_SEED   = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DRAW,
    ST_MOD,
    ST_DEADLINE,
    ST_ONSET,
    ST_MUL,
    ST_CREDIT,
    ST_EMIT
  } state_e;

  // start and finish strobes of a serial unit
  typedef struct packed {
    logic start;
  } unit_cmd_t;

  typedef struct packed {
    logic done;
  } unit_sts_t;

  // xorshift32 with shifts 13, 17, 5
  function automatic logic [RngBits-1:0] xorshift(input logic [RngBits-1:0] x);
    logic [RngBits-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // now earlier than deadline, by the sign of the wrapping difference
  function automatic logic is_before(input time_t now, input time_t dl);
    time_t diff;
    diff = now - dl;
    return diff[TimeBits-1];
  endfunction

endpackage

>>> rtl/core/cgate_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module cgate_rem (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cgate_pkg::unit_cmd_t                cmd_i,
  input  logic [cgate_pkg::RngBits-1:0]       dividend_i,
  input  logic [cgate_pkg::DivBits-1:0]       divisor_i,
  output cgate_pkg::unit_sts_t                sts_o,
  output logic [cgate_pkg::DelayBits-1:0]     rem_o
);

  localparam int CntBits = $clog2(cgate_pkg::RngBits + 1);

  logic                             busy_q;
  logic                             done_q;
  logic [CntBits-1:0]               cnt_q;
  logic [cgate_pkg::RngBits-1:0]    shf_q;
  logic [cgate_pkg::DivBits-1:0]    rem_q;
  logic [cgate_pkg::DivBits-1:0]    div_q;
  logic [cgate_pkg::DivBits:0]      trial;
  logic                             fits;
  logic [cgate_pkg::DivBits-1:0]    rem_d;

  // shift the next dividend bit in, subtract when the divisor fits
  always_comb begin
    trial = {rem_q, shf_q[cgate_pkg::RngBits-1]};
    fits  = trial >= {1'b0, div_q};
    if (fits) begin
      rem_d = cgate_pkg::DivBits'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[cgate_pkg::DivBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(cgate_pkg::RngBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      shf_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      shf_q <= shf_q << 1;
      rem_q <= rem_d;
    end
  end

  assign sts_o.done = done_q;
  assign rem_o      = rem_q[cgate_pkg::DelayBits-1:0];

endmodule

>>> rtl/core/cgate_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module cgate_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cgate_pkg::unit_cmd_t                cmd_i,
  input  logic [cgate_pkg::WinBits-1:0]       mcand_i,
  input  logic [cgate_pkg::RefillBits-1:0]    mplier_i,
  output cgate_pkg::unit_sts_t                sts_o,
  output logic [cgate_pkg::ProdBits-1:0]      prod_o
);

  localparam int CntBits = $clog2(cgate_pkg::RefillBits + 1);

  logic                               busy_q;
  logic                               done_q;
  logic [CntBits-1:0]                 cnt_q;
  logic [cgate_pkg::ProdBits-1:0]     acc_q;
  logic [cgate_pkg::ProdBits-1:0]     mcand_q;
  logic [cgate_pkg::RefillBits-1:0]   mplier_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(cgate_pkg::RefillBits);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == CntBits'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q    <= '0;
      mcand_q  <= cgate_pkg::ProdBits'(mcand_i);
      mplier_q <= mplier_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign sts_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

>>> rtl/core/credit_gate_with_onset_offset_delay.sv
// top level of the credit gate with random onset and offset delay
// bypassed and immediate queries go from accept through dispatch and emit to the result;
//   a send query that draws an onset delay and refills credit also runs the serial units
// the serial remainder unit and the serial multiplier set the worst case
// throughput: one transaction in flight; the next is taken the cycle after its result is registered
// reset: registers take their default values and the gate state is cleared
`timescale 1ns / 1ps

module credit_gate_with_onset_offset_delay (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic [cgate_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [cgate_pkg::CfgDataBits-1:0]     cfg_data_i,
  // query channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  opcode_i,
  input  logic [cgate_pkg::NowBits-1:0]         now_us_i,
  input  logic                                  inject_pending_i,
  input  logic                                  buttons_changed_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  allow_o
);

  // configuration registers
  logic                               enable_q;
  logic [cgate_pkg::DelayBits-1:0]    onset_min_q;
  logic [cgate_pkg::DelayBits-1:0]    onset_max_q;
  logic [cgate_pkg::DelayBits-1:0]    offset_min_q;
  logic [cgate_pkg::DelayBits-1:0]    offset_max_q;
  logic [cgate_pkg::RefillBits-1:0]   refill_q;
  logic [cgate_pkg::RngBits-1:0]      seed_q;

  // gate state
  logic [cgate_pkg::RngBits-1:0]      rng_q;
  logic                               burst_q;
  logic                               stop_pend_q;
  logic [cgate_pkg::CreditBits-1:0]   credit_q;
  logic                               grant_vld_q;
  cgate_pkg::time_t                   onset_dl_q;
  cgate_pkg::time_t                   stop_dl_q;
  cgate_pkg::time_t                   last_grant_q;

  // transaction in flight
  cgate_pkg::state_e                  state_q, state_d;
  cgate_pkg::opcode_e                 op_q;
  cgate_pkg::time_t                   now_q;
  logic                               pend_q;
  logic                               btn_q;
  logic [cgate_pkg::DelayBits-1:0]    delay_q;
  logic                               res_q;

  // output register
  logic                               out_valid_q;
  logic                               allow_q;

  // serial units
  cgate_pkg::unit_cmd_t               rem_cmd, mul_cmd;
  cgate_pkg::unit_sts_t               rem_sts, mul_sts;
  logic [cgate_pkg::DelayBits-1:0]    rem;
  logic [cgate_pkg::ProdBits-1:0]     prod;

  // datapath helpers
  logic [cgate_pkg::DelayBits-1:0]    lo, hi;
  logic                               no_draw;
  logic [cgate_pkg::RngBits-1:0]      rng_next;
  logic [cgate_pkg::DivBits-1:0]      span;
  cgate_pkg::time_t                   deadline;
  logic                               onset_wait;
  logic                               stop_wait;
  cgate_pkg::time_t                   dt_full;
  logic [cgate_pkg::WinBits-1:0]      dt;
  logic [cgate_pkg::SumBits-1:0]      credit_sum;
  logic [cgate_pkg::CreditBits-1:0]   credit_sat;
  logic                               credit_ok;
  logic                               emit_go;
  logic                               cfg_hit;
  logic [cgate_pkg::RngBits-1:0]      seed_new;

  // delay bounds follow the query kind
  always_comb begin
    if (op_q == cgate_pkg::OP_STOP) begin
      lo = offset_min_q;
      hi = offset_max_q;
    end else begin
      lo = onset_min_q;
      hi = onset_max_q;
    end
    no_draw  = hi <= lo;
    rng_next = cgate_pkg::xorshift(rng_q);
    span     = cgate_pkg::DivBits'(hi) - cgate_pkg::DivBits'(lo) + cgate_pkg::DivBits'(1);
    deadline = now_q + cgate_pkg::TimeBits'(delay_q);
  end

  // deadline checks and credit arithmetic
  always_comb begin
    onset_wait = cgate_pkg::is_before(now_q, onset_dl_q);
    stop_wait  = cgate_pkg::is_before(now_q, stop_dl_q);
    // refill window is zero until the first grant, then capped
    dt_full    = grant_vld_q ? (now_q - last_grant_q) : '0;
    if (dt_full > cgate_pkg::TimeBits'(cgate_pkg::WinMax)) begin
      dt = cgate_pkg::WinBits'(cgate_pkg::WinMax);
    end else begin
      dt = dt_full[cgate_pkg::WinBits-1:0];
    end
    credit_sum = cgate_pkg::SumBits'(credit_q) + cgate_pkg::SumBits'(prod);
    if (credit_sum > cgate_pkg::SumBits'(cgate_pkg::CreditCap)) begin
      credit_sat = cgate_pkg::CreditCap;
    end else begin
      credit_sat = credit_sum[cgate_pkg::CreditBits-1:0];
    end
    credit_ok = credit_sat >= cgate_pkg::CreditOne;
  end

  // result register is free or being drained this cycle
  assign emit_go = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cgate_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = cgate_pkg::ST_DISPATCH;
        end
      end
      cgate_pkg::ST_DISPATCH: begin
        priority if (!enable_q) begin
          state_d = cgate_pkg::ST_EMIT;
        end else if (op_q == cgate_pkg::OP_SEND) begin
          priority if (!pend_q || btn_q) begin
            state_d = cgate_pkg::ST_EMIT;
          end else if (!burst_q) begin
            state_d = cgate_pkg::ST_DRAW;
          end else begin
            state_d = cgate_pkg::ST_ONSET;
          end
        end else if (!stop_pend_q) begin
          state_d = cgate_pkg::ST_DRAW;
        end else begin
          state_d = cgate_pkg::ST_EMIT;
        end
      end
      cgate_pkg::ST_DRAW: begin
        state_d = no_draw ? cgate_pkg::ST_DEADLINE : cgate_pkg::ST_MOD;
      end
      cgate_pkg::ST_MOD: begin
        if (rem_sts.done) begin
          state_d = cgate_pkg::ST_DEADLINE;
        end
      end
      cgate_pkg::ST_DEADLINE: begin
        state_d = (op_q == cgate_pkg::OP_SEND) ? cgate_pkg::ST_ONSET : cgate_pkg::ST_EMIT;
      end
      cgate_pkg::ST_ONSET: begin
        state_d = onset_wait ? cgate_pkg::ST_EMIT : cgate_pkg::ST_MUL;
      end
      cgate_pkg::ST_MUL: begin
        if (mul_sts.done) begin
          state_d = cgate_pkg::ST_CREDIT;
        end
      end
      cgate_pkg::ST_CREDIT: begin
        state_d = cgate_pkg::ST_EMIT;
      end
      cgate_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_d = cgate_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cgate_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o    = state_q == cgate_pkg::ST_IDLE;
    rem_cmd.start = (state_q == cgate_pkg::ST_DRAW) && !no_draw;
    mul_cmd.start = (state_q == cgate_pkg::ST_ONSET) && !onset_wait;
  end

  // config write to a listed register
  always_comb begin
    cfg_hit  = 1'b0;
    seed_new = seed_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        cgate_pkg::REG_ENABLE,
        cgate_pkg::REG_ONSET_MIN,
        cgate_pkg::REG_ONSET_MAX,
        cgate_pkg::REG_OFFSET_MIN,
        cgate_pkg::REG_OFFSET_MAX,
        cgate_pkg::REG_REFILL: begin
          cfg_hit = 1'b1;
        end
        cgate_pkg::REG_RNG_SEED: begin
          cfg_hit  = 1'b1;
          seed_new = cfg_data_i[cgate_pkg::RngBits-1:0];
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // control state, config registers and gate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cgate_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      enable_q     <= cgate_pkg::EnableRst;
      onset_min_q  <= cgate_pkg::OnsetMinRst;
      onset_max_q  <= cgate_pkg::OnsetMaxRst;
      offset_min_q <= cgate_pkg::OffsetMinRst;
      offset_max_q <= cgate_pkg::OffsetMaxRst;
      refill_q     <= cgate_pkg::RefillRst;
      seed_q       <= cgate_pkg::SeedRst;
      rng_q        <= cgate_pkg::SeedRst;
      burst_q      <= 1'b0;
      stop_pend_q  <= 1'b0;
      credit_q     <= cgate_pkg::CreditOne;
      grant_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // result register drains on its own handshake
      if (state_q == cgate_pkg::ST_EMIT && emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        cgate_pkg::ST_DISPATCH: begin
          if (enable_q) begin
            if (op_q == cgate_pkg::OP_SEND) begin
              if (!pend_q && !btn_q) begin
                // nothing to send closes the burst
                burst_q <= 1'b0;
              end else begin
                stop_pend_q <= 1'b0;
                if (!btn_q && !burst_q) begin
                  burst_q <= 1'b1;
                end
              end
            end else if (!stop_pend_q) begin
              stop_pend_q <= 1'b1;
            end else if (!stop_wait) begin
              // offset delay ran out, stop goes through
              stop_pend_q <= 1'b0;
              burst_q     <= 1'b0;
            end
          end
        end
        cgate_pkg::ST_DRAW: begin
          if (!no_draw) begin
            rng_q <= rng_next;
          end
        end
        cgate_pkg::ST_CREDIT: begin
          if (credit_ok) begin
            credit_q    <= credit_sat - cgate_pkg::CreditOne;
            grant_vld_q <= 1'b1;
          end else begin
            credit_q <= credit_sat;
          end
        end
        default: begin
        end
      endcase

      // config write sets the register and restarts the gate
      if (cfg_hit) begin
        unique case (cfg_index_i)
          cgate_pkg::REG_ENABLE:     enable_q     <= cfg_data_i[0];
          cgate_pkg::REG_ONSET_MIN:  onset_min_q  <= cfg_data_i[cgate_pkg::DelayBits-1:0];
          cgate_pkg::REG_ONSET_MAX:  onset_max_q  <= cfg_data_i[cgate_pkg::DelayBits-1:0];
          cgate_pkg::REG_OFFSET_MIN: offset_min_q <= cfg_data_i[cgate_pkg::DelayBits-1:0];
          cgate_pkg::REG_OFFSET_MAX: offset_max_q <= cfg_data_i[cgate_pkg::DelayBits-1:0];
          cgate_pkg::REG_REFILL:     refill_q     <= cfg_data_i[cgate_pkg::RefillBits-1:0];
          cgate_pkg::REG_RNG_SEED:   seed_q       <= seed_new;
          default: begin
          end
        endcase
        // zero seed would lock the generator
        rng_q       <= (seed_new == '0) ? cgate_pkg::SeedFallback : seed_new;
        burst_q     <= 1'b0;
        stop_pend_q <= 1'b0;
        credit_q    <= cgate_pkg::CreditOne;
        grant_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= cgate_pkg::opcode_e'(opcode_i);
      now_q  <= cgate_pkg::TimeBits'(now_us_i);
      pend_q <= inject_pending_i;
      btn_q  <= buttons_changed_i;
    end
    if (state_q == cgate_pkg::ST_EMIT && emit_go) begin
      allow_q <= res_q;
    end
    unique case (state_q)
      cgate_pkg::ST_DISPATCH: begin
        // immediate answers; drawing paths set the result later
        if (!enable_q) begin
          res_q <= 1'b1;
        end else if (op_q == cgate_pkg::OP_SEND) begin
          res_q <= 1'b1;
        end else begin
          res_q <= !stop_wait;
        end
      end
      cgate_pkg::ST_DRAW: begin
        if (no_draw) begin
          delay_q <= lo;
        end
      end
      cgate_pkg::ST_MOD: begin
        if (rem_sts.done) begin
          delay_q <= lo + rem;
        end
      end
      cgate_pkg::ST_DEADLINE: begin
        if (op_q == cgate_pkg::OP_SEND) begin
          onset_dl_q <= deadline;
        end else begin
          stop_dl_q <= deadline;
          res_q     <= 1'b0;
        end
      end
      cgate_pkg::ST_ONSET: begin
        if (onset_wait) begin
          res_q <= 1'b0;
        end
      end
      cgate_pkg::ST_CREDIT: begin
        res_q <= credit_ok;
        if (credit_ok) begin
          last_grant_q <= now_q;
        end
      end
      default: begin
      end
    endcase
  end

  // random delay: rng word modulo the span, one bit per cycle
  cgate_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (rem_cmd),
    .dividend_i (rng_next),
    .divisor_i  (span),
    .sts_o      (rem_sts),
    .rem_o      (rem)
  );

  // refill amount: elapsed window times refill rate
  cgate_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mul_cmd),
    .mcand_i  (dt),
    .mplier_i (refill_q),
    .sts_o    (mul_sts),
    .prod_o   (prod)
  );

  assign out_valid_o = out_valid_q;
  assign allow_o     = allow_q;

endmodule

>>> rtl/core/cgate_checker.sv
// port-level checker of the credit gate and its bind
`timescale 1ns / 1ps
`include "credit_gate_with_onset_offset_delay_assert.svh"

module cgate_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic allow_i
);

  // a stalled result stays and keeps its value
  `CG_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `CG_ASSERT_NEXT(a_allow_hold, out_valid_i && !out_ready_i, $stable(allow_i), "allow changed while stalled")

  // only one transaction at work at a time
  `CG_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i, "input taken while busy")

  // a new result shows up as the engine returns to idle
  `CG_ASSERT_SAME(a_result_at_idle, $rose(out_valid_i), in_ready_i, "result while engine busy")

endmodule

bind credit_gate_with_onset_offset_delay cgate_checker u_cgate_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .allow_i     (allow_o)
);
